[rtl/bps_pkg.sv]
// ----------------------------------------------------------------------------
// bps_pkg
// Shared types and constants of the bottleneck path solver: request and
// result payloads, operation codes and default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package bps_pkg;

  // Fixed field widths of the request and result payloads
  localparam int NODE_FW   = 6;
  localparam int WEIGHT_FW = 16;
  localparam int COUNT_FW  = 7;

  // Default sizes
  localparam int DEF_MAX_NODES   = 64;
  localparam int DEF_MAX_EDGES   = 256;
  localparam int DEF_WEIGHT_BITS = 16;

  // Reset value of the node count register
  localparam logic [COUNT_FW-1:0] NODE_COUNT_RESET = 7'd64;

  // Operation codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_SOLVE = 1'b1;

  typedef struct packed {
    logic                 operation;
    logic [NODE_FW-1:0]   end_a;
    logic [NODE_FW-1:0]   end_b;
    logic [WEIGHT_FW-1:0] edge_weight;
    logic [NODE_FW-1:0]   start_node;
  } in_req_t;

  typedef struct packed {
    logic [NODE_FW-1:0]   node_index;
    logic [WEIGHT_FW-1:0] best_cost;
    logic                 reachable;
    logic                 edges_dropped;
    logic                 last;
  } out_res_t;

endpackage

`default_nettype wire

[rtl/bps_edge_store.sv]
// ----------------------------------------------------------------------------
// bps_edge_store
// Edge memory with fill count and overflow flag. Appends one edge per load
// request, drops edges once full, and serves one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bps_edge_store #(
  parameter int MAX_EDGES = bps_pkg::DEF_MAX_EDGES,
  parameter int WB        = bps_pkg::WEIGHT_FW,
  parameter int EDGE_AW   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1,
  parameter int CNT_W     = $clog2(MAX_EDGES + 1),
  parameter int ENTRY_W   = 2 * bps_pkg::NODE_FW + WB
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 ld_valid,
  input  wire bps_pkg::in_req_t     ld_req,
  input  wire logic                 clear,
  input  wire logic [EDGE_AW-1:0]   rd_addr,
  output logic      [ENTRY_W-1:0]   rd_data,
  output logic      [CNT_W-1:0]     edge_count,
  output logic                      overflow
);

  logic [ENTRY_W-1:0] mem [MAX_EDGES];
  logic [CNT_W-1:0]   count_r;
  logic               ovf_r;
  logic [ENTRY_W-1:0] rd_data_r;
  logic               do_load;
  logic               has_room;

  assign do_load  = ld_valid && (ld_req.operation == bps_pkg::OP_LOAD);
  assign has_room = (count_r < CNT_W'(MAX_EDGES));

  // Append the edge at the fill count
  always_ff @(posedge clk) begin
    if (do_load && has_room) begin
      mem[count_r[EDGE_AW-1:0]] <= {ld_req.end_a, ld_req.end_b, ld_req.edge_weight[WB-1:0]};
    end
    rd_data_r <= mem[rd_addr];
  end

  // Track fill count and overflow; empty both after a solve
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else if (clear) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else if (do_load) begin
      if (has_room) begin
        count_r <= count_r + CNT_W'(1);
      end else begin
        ovf_r <= 1'b1;
      end
    end
  end

  assign rd_data    = rd_data_r;
  assign edge_count = count_r;
  assign overflow   = ovf_r;

endmodule

`default_nettype wire

[rtl/bps_node_mem.sv]
// ----------------------------------------------------------------------------
// bps_node_mem
// Per-node cost memory: one write port and two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module bps_node_mem #(
  parameter int DEPTH = bps_pkg::DEF_MAX_NODES,
  parameter int AW    = $clog2(DEPTH),
  parameter int DW    = bps_pkg::WEIGHT_FW + 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] ra_addr,
  input  wire logic [AW-1:0] rb_addr,
  output logic      [DW-1:0] qa,
  output logic      [DW-1:0] qb
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] qa_r;
  logic [DW-1:0] qb_r;

  // Write, and register both read ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    qa_r <= mem[ra_addr];
    qb_r <= mem[rb_addr];
  end

  assign qa = qa_r;
  assign qb = qb_r;

endmodule

`default_nettype wire

[rtl/bottleneck_path_solver_unit.sv]
// ----------------------------------------------------------------------------
// bottleneck_path_solver_unit
// Minimax path solver: loads undirected weighted edges, then for a start
// node finds per node the least possible largest edge weight on a path.
//
//   channel  ports                        direction  handshake
//   request  start, busy, in_req          in         start && !busy
//   result   out_valid, out_res           out        out_valid, one cycle
//   config   cfg_valid, cfg_ready, cfg_data  in      cfg_valid && cfg_ready
//
// Loads can follow each other every cycle while busy is low.
// A solve sweeps the node memory, then relaxes the edge store pass after
// pass until a pass changes nothing. An edge inside the node count goes
// through edge read, node reads, relax toward b and relax toward a; an
// edge outside it through edge read and node reads only. Then the solve
// emits one result per node. busy is high for the whole solve.
// Reset clears the edge count and the overflow flag and sets the node count (64).
// The receiver cannot stall; results are never held.
// ----------------------------------------------------------------------------
`default_nettype none

module bottleneck_path_solver_unit #(
  parameter int MAX_NODES   = bps_pkg::DEF_MAX_NODES,
  parameter int MAX_EDGES   = bps_pkg::DEF_MAX_EDGES,
  parameter int WEIGHT_BITS = bps_pkg::DEF_WEIGHT_BITS
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire bps_pkg::in_req_t                 in_req,
  output logic                                  out_valid,
  output bps_pkg::out_res_t                     out_res,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [bps_pkg::COUNT_FW-1:0]     cfg_data
);

  localparam int WB      = (WEIGHT_BITS < bps_pkg::WEIGHT_FW) ? WEIGHT_BITS
                                                               : bps_pkg::WEIGHT_FW;
  localparam int NODE_AW = $clog2(MAX_NODES);
  localparam int EDGE_AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CNT_W   = $clog2(MAX_EDGES + 1);
  localparam int NFW     = bps_pkg::NODE_FW;
  localparam int CFW     = bps_pkg::COUNT_FW;
  localparam int ENTRY_W = 2 * NFW + WB;
  localparam int NDW     = WB + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_EDGE, S_NODE, S_REL1, S_REL2, S_ORD, S_OEMIT
  } state_t;

  state_t               state_r;
  logic [CFW-1:0]       node_count_r;
  logic [NFW-1:0]       start_r;
  logic [NODE_AW-1:0]   cidx_r;
  logic [EDGE_AW-1:0]   eidx_r;
  logic                 changed_r;
  logic [NFW-1:0]       ea_r;
  logic [NFW-1:0]       eb_r;
  logic [WB-1:0]        ew_r;
  logic [NDW-1:0]       qa_r;
  logic [NDW-1:0]       bval_r;
  logic [CFW-1:0]       j_r;
  logic                 out_valid_r;
  bps_pkg::out_res_t    out_res_r;

  logic [CFW-1:0]       n_eff;
  logic                 start_ok;
  logic                 accept;
  logic                 edge_clear;
  logic [ENTRY_W-1:0]   edge_q;
  logic [CNT_W-1:0]     edge_count;
  logic                 overflow;
  logic [NFW-1:0]       q_a;
  logic [NFW-1:0]       q_b;
  logic                 in_range;
  logic                 last_edge;
  logic                 last_node;

  logic                 nm_we;
  logic [NODE_AW-1:0]   nm_waddr;
  logic [NDW-1:0]       nm_wdata;
  logic [NODE_AW-1:0]   nm_ra;
  logic [NODE_AW-1:0]   nm_rb;
  logic [NDW-1:0]       nm_qa;
  logic [NDW-1:0]       nm_qb;

  logic [WB-1:0]        cand_b;
  logic                 upd_b;
  logic [WB-1:0]        cand_a;
  logic                 upd_a;

  // Clamp the node count into 1..MAX_NODES
  always_comb begin
    if (node_count_r == '0) begin
      n_eff = CFW'(1);
    end else if (node_count_r > CFW'(MAX_NODES)) begin
      n_eff = CFW'(MAX_NODES);
    end else begin
      n_eff = node_count_r;
    end
  end

  assign accept    = start && (state_r == S_IDLE);
  assign start_ok  = (CFW'(start_r) < n_eff);
  assign q_a       = edge_q[ENTRY_W-1 -: NFW];
  assign q_b       = edge_q[ENTRY_W-NFW-1 -: NFW];
  assign in_range  = (CFW'(q_a) < n_eff) && (CFW'(q_b) < n_eff);
  assign last_edge = ((CNT_W'(eidx_r) + CNT_W'(1)) == edge_count);
  assign last_node = ((j_r + CFW'(1)) == n_eff);
  assign edge_clear = (state_r == S_OEMIT) && last_node;

  bps_edge_store #(
    .MAX_EDGES (MAX_EDGES),
    .WB        (WB)
  ) u_edge_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .ld_valid   (accept),
    .ld_req     (in_req),
    .clear      (edge_clear),
    .rd_addr    (eidx_r),
    .rd_data    (edge_q),
    .edge_count (edge_count),
    .overflow   (overflow)
  );

  // Relax in both directions over the latched edge
  always_comb begin
    cand_b = (nm_qa[WB-1:0] > ew_r) ? nm_qa[WB-1:0] : ew_r;
    upd_b  = nm_qa[WB] && (!nm_qb[WB] || (nm_qb[WB-1:0] > cand_b));
    cand_a = (bval_r[WB-1:0] > ew_r) ? bval_r[WB-1:0] : ew_r;
    upd_a  = (ea_r != eb_r) && bval_r[WB] &&
             (!qa_r[WB] || (qa_r[WB-1:0] > cand_a));
  end

  // Steer the node memory ports
  always_comb begin
    nm_we    = 1'b0;
    nm_waddr = cidx_r;
    nm_wdata = '0;
    nm_ra    = j_r[NODE_AW-1:0];
    nm_rb    = q_b[NODE_AW-1:0];
    case (state_r)
      S_CLEAR: begin
        nm_we    = 1'b1;
        nm_waddr = cidx_r;
        nm_wdata = (start_ok && (CFW'(start_r) == CFW'(cidx_r))) ? {1'b1, {WB{1'b0}}}
                                                                 : '0;
      end
      S_NODE: begin
        nm_ra = q_a[NODE_AW-1:0];
        nm_rb = q_b[NODE_AW-1:0];
      end
      S_REL1: begin
        nm_we    = upd_b;
        nm_waddr = eb_r[NODE_AW-1:0];
        nm_wdata = {1'b1, cand_b};
      end
      S_REL2: begin
        nm_we    = upd_a;
        nm_waddr = ea_r[NODE_AW-1:0];
        nm_wdata = {1'b1, cand_a};
      end
      default: begin
        nm_we = 1'b0;
      end
    endcase
  end

  bps_node_mem #(
    .DEPTH (MAX_NODES),
    .DW    (NDW)
  ) u_node_mem (
    .clk     (clk),
    .we      (nm_we),
    .waddr   (nm_waddr),
    .wdata   (nm_wdata),
    .ra_addr (nm_ra),
    .rb_addr (nm_rb),
    .qa      (nm_qa),
    .qb      (nm_qb)
  );

  // Hold the node count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= bps_pkg::NODE_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      node_count_r <= cfg_data;
    end
  end

  // Sequence the solve and register the results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      changed_r   <= 1'b0;
      cidx_r      <= '0;
      eidx_r      <= '0;
      j_r         <= '0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept && (in_req.operation == bps_pkg::OP_SOLVE)) begin
            start_r <= in_req.start_node;
            cidx_r  <= '0;
            state_r <= S_CLEAR;
          end
        end
        S_CLEAR: begin
          if (cidx_r == NODE_AW'(MAX_NODES - 1)) begin
            eidx_r    <= '0;
            j_r       <= '0;
            changed_r <= 1'b0;
            if (edge_count == '0 || !start_ok) begin
              state_r <= S_ORD;
            end else begin
              state_r <= S_EDGE;
            end
          end else begin
            cidx_r <= cidx_r + NODE_AW'(1);
          end
        end
        S_EDGE: begin
          state_r <= S_NODE;
        end
        S_NODE: begin
          ea_r <= q_a;
          eb_r <= q_b;
          ew_r <= edge_q[WB-1:0];
          if (in_range) begin
            state_r <= S_REL1;
          end else if (last_edge) begin
            eidx_r    <= '0;
            changed_r <= 1'b0;
            state_r   <= changed_r ? S_EDGE : S_ORD;
          end else begin
            eidx_r  <= eidx_r + EDGE_AW'(1);
            state_r <= S_EDGE;
          end
        end
        S_REL1: begin
          qa_r   <= nm_qa;
          bval_r <= upd_b ? {1'b1, cand_b} : nm_qb;
          if (upd_b) begin
            changed_r <= 1'b1;
          end
          state_r <= S_REL2;
        end
        S_REL2: begin
          if (last_edge) begin
            eidx_r    <= '0;
            changed_r <= 1'b0;
            state_r   <= (changed_r || upd_a) ? S_EDGE : S_ORD;
          end else begin
            if (upd_a) begin
              changed_r <= 1'b1;
            end
            eidx_r  <= eidx_r + EDGE_AW'(1);
            state_r <= S_EDGE;
          end
        end
        S_ORD: begin
          state_r <= S_OEMIT;
        end
        S_OEMIT: begin
          out_valid_r              <= 1'b1;
          out_res_r.node_index     <= j_r[NFW-1:0];
          out_res_r.best_cost      <= nm_qa[WB] ? bps_pkg::WEIGHT_FW'(nm_qa[WB-1:0]) : '0;
          out_res_r.reachable      <= nm_qa[WB];
          out_res_r.edges_dropped  <= overflow;
          out_res_r.last           <= last_node;
          if (last_node) begin
            state_r <= S_IDLE;
          end else begin
            j_r     <= j_r + CFW'(1);
            state_r <= S_ORD;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

`default_nettype wire

[test/bottleneck_path_solver_unit_tb.sv]
// ----------------------------------------------------------------------------
// bottleneck_path_solver_unit_tb
// Self-checking bench for the minimax path solver. Edge loads and solve
// requests are queued, then driven with random gaps. Each accepted request
// feeds a local minimax predictor. Every result strobe is checked field by
// field against the oldest predicted result. The node count register is
// rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module bottleneck_path_solver_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int EDGE_CAP      = bps_pkg::DEF_MAX_EDGES;
  localparam int NODE_CAP      = bps_pkg::DEF_MAX_NODES;
  localparam int SETTLE_CYCLES = 16;
  localparam int TAIL_CYCLES   = 300;

  logic                         clk       = 1'b0;
  logic                         rst_n     = 1'b0;
  logic                         start     = 1'b0;
  logic                         busy;
  bps_pkg::in_req_t             in_req    = '0;
  logic                         out_valid;
  bps_pkg::out_res_t            out_res;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [bps_pkg::COUNT_FW-1:0] cfg_data  = '0;

  // Predictor state: edge store, overflow flag and node count copy
  logic [bps_pkg::NODE_FW-1:0]   edge_a_q [EDGE_CAP];
  logic [bps_pkg::NODE_FW-1:0]   edge_b_q [EDGE_CAP];
  logic [bps_pkg::WEIGHT_FW-1:0] edge_w_q [EDGE_CAP];
  int                            edge_total     = 0;
  bit                            overflow_seen  = 1'b0;
  logic [bps_pkg::COUNT_FW-1:0]  node_count_cfg = bps_pkg::NODE_COUNT_RESET;

  bps_pkg::in_req_t  pending_reqs [$];
  bps_pkg::out_res_t expected_costs [$];
  int                err_count = 0;
  bit                req_taken = 1'b0;
  int                idle_left = 0;
  bit                no_idle   = 1'b0;

  bottleneck_path_solver_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

  // Clamp the register value to the node range the solver uses
  function automatic int active_nodes(input logic [bps_pkg::COUNT_FW-1:0] cfg);
    if (cfg == 0) return 1;
    if (cfg > NODE_CAP) return NODE_CAP;
    return int'(cfg);
  endfunction

  function automatic bps_pkg::in_req_t random_req();
    bps_pkg::in_req_t r;
    r.operation   = 1'($urandom_range(0, 1));
    r.end_a       = bps_pkg::NODE_FW'($urandom_range(0, 63));
    r.end_b       = bps_pkg::NODE_FW'($urandom_range(0, 63));
    r.edge_weight = bps_pkg::WEIGHT_FW'($urandom_range(0, 65535));
    r.start_node  = bps_pkg::NODE_FW'($urandom_range(0, 63));
    return r;
  endfunction

  // Mostly short gaps, a few long ones, none in burst phases
  function automatic int pick_gap();
    int roll;
    if (no_idle) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic int pick_node(input int n);
    if ($urandom_range(0, 99) < 85) return $urandom_range(0, n - 1);
    return $urandom_range(0, 63);
  endfunction

  function automatic int pick_weight();
    int roll;
    roll = $urandom_range(0, 3);
    if (roll < 2) return $urandom_range(0, 65535);
    if (roll == 2) return $urandom_range(0, 7);
    return ($urandom_range(0, 1) != 0) ? 65535 : 0;
  endfunction

  // Append an edge, or flag the drop when the store is full
  task automatic store_edge(input bps_pkg::in_req_t r);
    if (edge_total < EDGE_CAP) begin
      edge_a_q[edge_total] = r.end_a;
      edge_b_q[edge_total] = r.end_b;
      edge_w_q[edge_total] = r.edge_weight;
      edge_total++;
    end else begin
      overflow_seen = 1'b1;
    end
  endtask

  // Relax all in-range edges until stable, then queue one result per node
  task automatic predict_minimax(input logic [bps_pkg::NODE_FW-1:0] src);
    logic [bps_pkg::WEIGHT_FW-1:0] cost [NODE_CAP];
    bit                            seen [NODE_CAP];
    bit                            changed;
    int                            n, i, e, dir, u, v;
    logic [bps_pkg::WEIGHT_FW-1:0] cand;
    bps_pkg::out_res_t             res;
    n = active_nodes(node_count_cfg);
    for (i = 0; i < NODE_CAP; i++) begin
      cost[i] = '0;
      seen[i] = 1'b0;
    end
    if (src < n) begin
      seen[src] = 1'b1;
      changed   = 1'b1;
      while (changed) begin
        changed = 1'b0;
        for (e = 0; e < edge_total; e++) begin
          if (edge_a_q[e] < n && edge_b_q[e] < n) begin
            for (dir = 0; dir < 2; dir++) begin
              u = (dir == 0) ? edge_a_q[e] : edge_b_q[e];
              v = (dir == 0) ? edge_b_q[e] : edge_a_q[e];
              if (seen[u]) begin
                cand = (cost[u] > edge_w_q[e]) ? cost[u] : edge_w_q[e];
                if (!seen[v] || cost[v] > cand) begin
                  cost[v] = cand;
                  seen[v] = 1'b1;
                  changed = 1'b1;
                end
              end
            end
          end
        end
      end
    end
    for (i = 0; i < n; i++) begin
      res.node_index    = bps_pkg::NODE_FW'(i);
      res.best_cost     = seen[i] ? cost[i] : '0;
      res.reachable     = seen[i];
      res.edges_dropped = overflow_seen;
      res.last          = (i == n - 1);
      expected_costs.insert(expected_costs.size(), res);
    end
    edge_total    = 0;
    overflow_seen = 1'b0;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Predict on each accepted request, check each result strobe
  always @(posedge clk) begin : monitor
    bps_pkg::out_res_t want;
    req_taken = rst_n && start && !busy;
    if (req_taken) begin
      if (in_req.operation == bps_pkg::OP_LOAD) begin
        store_edge(in_req);
      end else begin
        predict_minimax(in_req.start_node);
      end
    end
    if (rst_n && out_valid) begin
      if (expected_costs.size() == 0) begin
        err_count++;
        $display("%0t: unexpected result, expected none, actual node %0d cost %0d",
                 $time, out_res.node_index, out_res.best_cost);
      end else begin
        want = expected_costs.pop_front();
        check_field("node_index", want.node_index, out_res.node_index);
        check_field("best_cost", want.best_cost, out_res.best_cost);
        check_field("reachable", want.reachable, out_res.reachable);
        check_field("edges_dropped", want.edges_dropped, out_res.edges_dropped);
        check_field("last", want.last, out_res.last);
      end
    end
  end

  // Drive the next request, hold it until taken, then idle for a gap
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !req_taken) begin
      // hold
    end else if (idle_left > 0) begin
      idle_left--;
      start  <= 1'b0;
      in_req <= random_req();
    end else if (pending_reqs.size() != 0) begin
      in_req    <= pending_reqs.pop_front();
      start     <= 1'b1;
      idle_left = pick_gap();
    end else begin
      start <= 1'b0;
    end
  end

  task automatic queue_load(input int a, input int b, input int w);
    bps_pkg::in_req_t r;
    r             = random_req();
    r.operation   = bps_pkg::OP_LOAD;
    r.end_a       = bps_pkg::NODE_FW'(a);
    r.end_b       = bps_pkg::NODE_FW'(b);
    r.edge_weight = bps_pkg::WEIGHT_FW'(w);
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  task automatic queue_solve(input int src);
    bps_pkg::in_req_t r;
    r            = random_req();
    r.operation  = bps_pkg::OP_SOLVE;
    r.start_node = bps_pkg::NODE_FW'(src);
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  task automatic queue_group(input int n, input int loads);
    int k;
    for (k = 0; k < loads; k++) queue_load(pick_node(n), pick_node(n), pick_weight());
    queue_solve(pick_node(n));
  endtask

  task automatic write_node_count(input logic [bps_pkg::COUNT_FW-1:0] value);
    repeat ($urandom_range(0, 3)) @(negedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    node_count_cfg = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_data  <= bps_pkg::COUNT_FW'($urandom_range(0, 127));
  endtask

  // Wait until every request is taken and every result has arrived
  task automatic wait_idle();
    @(posedge clk);
    while (pending_reqs.size() != 0 || start || expected_costs.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int ph, grp, roll, n;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset node count: empty store, extremes, self loop, duplicate edge
    queue_solve(0);
    queue_load(0, 63, 65535);
    queue_load(63, 1, 0);
    queue_load(5, 5, 7);
    queue_load(1, 2, 16'hAAAA);
    queue_load(2, 3, 16'h5555);
    queue_load(1, 2, 3);
    queue_solve(63);
    wait_idle();

    // Small graph: edge beyond node count, start beyond node count
    write_node_count(4);
    queue_load(0, 1, 10);
    queue_load(1, 2, 20);
    queue_load(2, 3, 5);
    queue_load(0, 5, 1);
    queue_load(3, 0, 100);
    queue_solve(0);
    queue_solve(5);
    wait_idle();

    // Zero node count acts as one node
    write_node_count(0);
    queue_solve(0);
    queue_load(0, 0, 9);
    queue_solve(1);
    wait_idle();

    // Oversized node count; chain loaded backward to force several passes
    write_node_count(127);
    queue_load(3, 4, 9);
    queue_load(2, 3, 4);
    queue_load(1, 2, 8);
    queue_load(0, 1, 2);
    queue_solve(0);
    wait_idle();

    // Random phases, each with a fresh node count
    for (ph = 0; ph < 6; ph++) begin
      no_idle = (ph == 2);
      roll = $urandom_range(0, 9);
      if (ph == 1) write_node_count(64);
      else if (roll < 6) write_node_count(bps_pkg::COUNT_FW'($urandom_range(2, 16)));
      else if (roll == 6) write_node_count(64);
      else if (roll == 7) write_node_count(0);
      else if (roll == 8) write_node_count(bps_pkg::COUNT_FW'($urandom_range(65, 127)));
      else write_node_count(bps_pkg::COUNT_FW'($urandom_range(17, 63)));
      n = active_nodes(node_count_cfg);
      for (grp = 0; grp < 3; grp++) begin
        if ($urandom_range(0, 9) == 0) queue_group(n, 0);
        else queue_group(n, $urandom_range(1, 7));
      end
      wait_idle();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0 && expected_costs.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
